// ===== rtl/sssp_pkg.sv =====
package sssp_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 256;
  localparam int unsigned WEIGHT_BITS  = 16;

  localparam int unsigned VTX_W    = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_W_W   = 16;
  localparam int unsigned DIST_W   = 32;

  localparam logic signed [DIST_W-1:0] INT_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] INT_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd1;

  typedef struct packed {
    logic [VTX_W-1:0]         edge_from;
    logic [VTX_W-1:0]         edge_to;
    logic signed [IN_W_W-1:0] edge_weight;
    logic                     last_edge;
  } req_t;

  typedef struct packed {
    logic [VTX_W-1:0]         vertex_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     edges_dropped;
    logic                     last_result;
  } res_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_SRC,
    ST_EDGE_RD,
    ST_DIST_RD,
    ST_RELAX,
    ST_EMIT_RD,
    ST_EMIT,
    ST_CYCLE
  } state_e;

endpackage

// ===== rtl/single_source_shortest_path_unit.sv =====
// Channel   Ports                                  Direction  Transfer
// request   start_i, busy_o, req_i                 in         start_i high while busy_o low
// result    res_valid_o, res_o                     out        valid high for a single cycle per result, no stall
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i       in         write at any edge with cfg_we_i
//
// A request that is not the last edge is taken and the block stays ready.
// The last edge starts the solve: the distances are cleared, the source is set, then N (the
// effective vertex count) passes run over the stored edges: edge read, distance read, relax
// (no relax for an edge out of range for the current count); then one result per vertex, or
// one negative-cycle result, which ends the last pass early. busy_o stays high throughout.
// Reset empties the edge store and sets vertex_count to 1 and source_vertex to 0.
module single_source_shortest_path_unit #(
  parameter int unsigned MAX_VERTICES = sssp_pkg::MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = sssp_pkg::MAX_EDGES,
  parameter int unsigned WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  sssp_pkg::req_t                 req_i,
  output logic                           res_valid_o,
  output sssp_pkg::res_t                 res_o,
  input  logic                           cfg_we_i,
  input  logic [sssp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sssp_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ETW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EDW = 2 * sssp_pkg::VTX_W + WEIGHT_BITS;
  localparam int unsigned DDW = sssp_pkg::DIST_W + 1;
  localparam int unsigned CW  = sssp_pkg::CFG_W;

  sssp_pkg::state_e state_q, state_d;

  logic [CW-1:0]  vc_q, vc_d;
  logic [sssp_pkg::VTX_W-1:0] src_q, src_d;
  logic [ETW-1:0] total_q, total_d;
  logic           drop_q, drop_d;
  logic [ETW-1:0] j_q, j_d;
  logic [CW-1:0]  p_q, p_d;
  logic [CW-1:0]  i_q, i_d;
  logic           res_valid_q, res_valid_d;
  sssp_pkg::res_t res_q, res_d;

  logic [CW-1:0]  nv;
  logic           accept;
  logic           load_drop;
  logic [31:0]    wraw;

  logic           edge_we, edge_re;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  logic [EDW-1:0] edge_wdata, edge_rdata;

  logic           dist_we, dist_re;
  logic [VAW-1:0] dist_waddr, dist_raddr_a, dist_raddr_b;
  logic [DDW-1:0] dist_wdata, dist_rdata_a, dist_rdata_b;

  logic [sssp_pkg::VTX_W-1:0] e_from, e_to;
  logic signed [sssp_pkg::DIST_W-1:0] e_weight;
  logic           e_out_of_range;
  logic signed [sssp_pkg::DIST_W-1:0] cand;
  logic           less;
  logic           improve;
  logic           pass_end;
  logic           check_pass;
  logic           src_ok;
  logic           last_vertex;

  always_comb begin
    if (vc_q == '0) begin
      nv = CW'(1);
    end else if (32'(vc_q) > MAX_VERTICES) begin
      nv = CW'(MAX_VERTICES);
    end else begin
      nv = vc_q;
    end
  end

  assign accept    = start_i && (state_q == sssp_pkg::ST_LOAD);
  assign load_drop = ({1'b0, req_i.edge_from} >= nv) || ({1'b0, req_i.edge_to} >= nv)
                   || (32'(total_q) >= MAX_EDGES);
  assign wraw      = {{(32 - sssp_pkg::IN_W_W){1'b0}}, req_i.edge_weight};

  assign e_from   = edge_rdata[EDW-1 -: sssp_pkg::VTX_W];
  assign e_to     = edge_rdata[EDW-sssp_pkg::VTX_W-1 -: sssp_pkg::VTX_W];
  assign e_weight = sssp_pkg::DIST_W'($signed(edge_rdata[WEIGHT_BITS-1:0]));
  assign e_out_of_range = ({1'b0, e_from} >= nv) || ({1'b0, e_to} >= nv);

  assign improve     = dist_rdata_a[DDW-1] && (!dist_rdata_b[DDW-1] || less);
  assign pass_end    = ((j_q + ETW'(1)) == total_q);
  assign check_pass  = (p_q == nv);
  assign src_ok      = ({1'b0, src_q} < nv);
  assign last_vertex = ((i_q + CW'(1)) == nv);

  sssp_edge_mem #(
    .DEPTH(MAX_EDGES),
    .AW   (EAW),
    .DW   (EDW)
  ) u_edge_mem (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_waddr),
    .wdata_i(edge_wdata),
    .re_i   (edge_re),
    .raddr_i(edge_raddr),
    .rdata_o(edge_rdata)
  );

  sssp_dist_mem #(
    .DEPTH(MAX_VERTICES),
    .AW   (VAW),
    .DW   (DDW)
  ) u_dist_mem (
    .clk_i    (clk_i),
    .we_i     (dist_we),
    .waddr_i  (dist_waddr),
    .wdata_i  (dist_wdata),
    .re_i     (dist_re),
    .raddr_a_i(dist_raddr_a),
    .raddr_b_i(dist_raddr_b),
    .rdata_a_o(dist_rdata_a),
    .rdata_b_o(dist_rdata_b)
  );

  sssp_relax_alu u_relax_alu (
    .dist_u_i(dist_rdata_a[sssp_pkg::DIST_W-1:0]),
    .weight_i(e_weight),
    .dist_v_i(dist_rdata_b[sssp_pkg::DIST_W-1:0]),
    .cand_o  (cand),
    .less_o  (less)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sssp_pkg::ST_LOAD: begin
        if (accept && req_i.last_edge) begin
          state_d = sssp_pkg::ST_INIT;
        end
      end
      sssp_pkg::ST_INIT: begin
        if (last_vertex) begin
          state_d = sssp_pkg::ST_SRC;
        end
      end
      sssp_pkg::ST_SRC: begin
        state_d = (total_q == '0) ? sssp_pkg::ST_EMIT_RD : sssp_pkg::ST_EDGE_RD;
      end
      sssp_pkg::ST_EDGE_RD: begin
        state_d = sssp_pkg::ST_DIST_RD;
      end
      sssp_pkg::ST_DIST_RD: begin
        if (!e_out_of_range) begin
          state_d = sssp_pkg::ST_RELAX;
        end else if (pass_end && check_pass) begin
          state_d = sssp_pkg::ST_EMIT_RD;
        end else begin
          state_d = sssp_pkg::ST_EDGE_RD;
        end
      end
      sssp_pkg::ST_RELAX: begin
        if (check_pass && improve) begin
          state_d = sssp_pkg::ST_CYCLE;
        end else if (pass_end && check_pass) begin
          state_d = sssp_pkg::ST_EMIT_RD;
        end else begin
          state_d = sssp_pkg::ST_EDGE_RD;
        end
      end
      sssp_pkg::ST_EMIT_RD: begin
        state_d = sssp_pkg::ST_EMIT;
      end
      sssp_pkg::ST_EMIT: begin
        state_d = last_vertex ? sssp_pkg::ST_LOAD : sssp_pkg::ST_EMIT_RD;
      end
      sssp_pkg::ST_CYCLE: begin
        state_d = sssp_pkg::ST_LOAD;
      end
      default: begin
        state_d = sssp_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    vc_d         = vc_q;
    src_d        = src_q;
    total_d      = total_q;
    drop_d       = drop_q;
    j_d          = j_q;
    p_d          = p_q;
    i_d          = i_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    edge_waddr   = total_q[EAW-1:0];
    edge_wdata   = {req_i.edge_from, req_i.edge_to, wraw[WEIGHT_BITS-1:0]};
    edge_raddr   = j_q[EAW-1:0];
    dist_we      = 1'b0;
    dist_re      = 1'b0;
    dist_waddr   = VAW'(i_q);
    dist_wdata   = '0;
    dist_raddr_a = VAW'(e_from);
    dist_raddr_b = VAW'(e_to);

    if (cfg_we_i) begin
      if (cfg_idx_i == sssp_pkg::REG_VERTEX_COUNT) begin
        vc_d = cfg_wdata_i;
      end
      if (cfg_idx_i == sssp_pkg::REG_SOURCE_VERTEX) begin
        src_d = cfg_wdata_i[sssp_pkg::VTX_W-1:0];
      end
    end

    unique case (state_q)
      sssp_pkg::ST_LOAD: begin
        if (accept) begin
          if (load_drop) begin
            drop_d = 1'b1;
          end else begin
            edge_we = 1'b1;
            total_d = total_q + ETW'(1);
          end
          i_d = '0;
        end
      end
      sssp_pkg::ST_INIT: begin
        dist_we    = 1'b1;
        dist_wdata = '0;
        i_d        = i_q + CW'(1);
      end
      sssp_pkg::ST_SRC: begin
        dist_we    = src_ok;
        dist_waddr = VAW'(src_q);
        dist_wdata = {1'b1, {sssp_pkg::DIST_W{1'b0}}};
        j_d        = '0;
        p_d        = CW'(1);
        i_d        = '0;
      end
      sssp_pkg::ST_EDGE_RD: begin
        edge_re = 1'b1;
      end
      sssp_pkg::ST_DIST_RD: begin
        if (e_out_of_range) begin
          drop_d = 1'b1;
          if (pass_end) begin
            j_d = '0;
            p_d = p_q + CW'(1);
          end else begin
            j_d = j_q + ETW'(1);
          end
        end else begin
          dist_re = 1'b1;
        end
      end
      sssp_pkg::ST_RELAX: begin
        if (improve && !check_pass) begin
          dist_we    = 1'b1;
          dist_waddr = VAW'(e_to);
          dist_wdata = {1'b1, cand};
        end
        if (pass_end) begin
          j_d = '0;
          p_d = p_q + CW'(1);
        end else begin
          j_d = j_q + ETW'(1);
        end
      end
      sssp_pkg::ST_EMIT_RD: begin
        dist_re      = 1'b1;
        dist_raddr_a = VAW'(i_q);
      end
      sssp_pkg::ST_EMIT: begin
        res_valid_d          = 1'b1;
        res_d.vertex_index   = i_q[sssp_pkg::VTX_W-1:0];
        res_d.reachable      = dist_rdata_a[DDW-1];
        res_d.distance       = dist_rdata_a[DDW-1] ? dist_rdata_a[sssp_pkg::DIST_W-1:0] : '0;
        res_d.negative_cycle = 1'b0;
        res_d.edges_dropped  = drop_q;
        res_d.last_result    = last_vertex;
        i_d                  = i_q + CW'(1);
        if (last_vertex) begin
          total_d = '0;
          drop_d  = 1'b0;
        end
      end
      sssp_pkg::ST_CYCLE: begin
        res_valid_d          = 1'b1;
        res_d.vertex_index   = '0;
        res_d.reachable      = 1'b0;
        res_d.distance       = '0;
        res_d.negative_cycle = 1'b1;
        res_d.edges_dropped  = drop_q;
        res_d.last_result    = 1'b1;
        total_d              = '0;
        drop_d               = 1'b0;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sssp_pkg::ST_LOAD;
      vc_q        <= CW'(1);
      src_q       <= '0;
      total_q     <= '0;
      drop_q      <= 1'b0;
      j_q         <= '0;
      p_q         <= '0;
      i_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      src_q       <= src_d;
      total_q     <= total_d;
      drop_q      <= drop_d;
      j_q         <= j_d;
      p_q         <= p_d;
      i_q         <= i_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o      = (state_q != sssp_pkg::ST_LOAD);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == sssp_pkg::ST_EMIT || $past(state_q) == sssp_pkg::ST_CYCLE))
    else $error("Result strobe without an emit state.");

  a_cycle_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.negative_cycle) |-> res_o.last_result)
    else $error("Negative cycle result is not the final result.");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_result) |-> (!busy_o && total_q == '0 && !drop_q))
    else $error("Block not reset for the next graph after the final result.");

  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= MAX_EDGES)
    else $error("Edge count exceeds store capacity.");

  a_unreachable_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.reachable) |-> (res_o.distance == '0))
    else $error("Unreachable vertex with nonzero distance.");

endmodule

// ===== rtl/sssp_edge_mem.sv =====
module sssp_edge_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 28
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sssp_dist_mem.sv =====
module sssp_dist_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 33
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_q;
  logic [DW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/sssp_relax_alu.sv =====
module sssp_relax_alu (
  input  logic signed [sssp_pkg::DIST_W-1:0] dist_u_i,
  input  logic signed [sssp_pkg::DIST_W-1:0] weight_i,
  input  logic signed [sssp_pkg::DIST_W-1:0] dist_v_i,
  output logic signed [sssp_pkg::DIST_W-1:0] cand_o,
  output logic                               less_o
);

  logic signed [sssp_pkg::DIST_W:0] sum;

  assign sum = {dist_u_i[sssp_pkg::DIST_W-1], dist_u_i}
             + {weight_i[sssp_pkg::DIST_W-1], weight_i};

  always_comb begin
    if (sum[sssp_pkg::DIST_W] != sum[sssp_pkg::DIST_W-1]) begin
      cand_o = sum[sssp_pkg::DIST_W] ? sssp_pkg::INT_MIN : sssp_pkg::INT_MAX;
    end else begin
      cand_o = sum[sssp_pkg::DIST_W-1:0];
    end
  end

  assign less_o = (cand_o < dist_v_i);

endmodule
